// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/cfasm_pkg.sv =====
// ----------------------------------------------------------------------------
// cfasm_pkg
// Shared codes and constants of the custom float add/sub/mul core.
// ----------------------------------------------------------------------------
package cfasm_pkg;

  // Request codes on the input channel
  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_SUB  = 2'd1,
    REQ_MUL  = 2'd2,
    REQ_CONV = 2'd3
  } req_t;

  // Internal kind of work an item carries down the pipeline
  typedef enum logic [1:0] {
    K_ADD,   // magnitude add, no renormalisation
    K_SUB,   // magnitude subtract, renormalised
    K_MUL,   // shift-and-add multiply, renormalised
    K_CONV   // integer conversion
  } kind_t;

  localparam int INT_BITS   = 64;  // width of the integer magnitude
  localparam int NORM_STEPS = 6;   // log2(INT_BITS) normaliser stages

endpackage

// ===== design/cfasm_mul_step.sv =====
// ----------------------------------------------------------------------------
// cfasm_mul_step
// One bit of the MSB-first shift-and-add multiply, with carry rescale.
// ----------------------------------------------------------------------------
module cfasm_mul_step #(
  parameter int WORD_BITS = 32,
  parameter int STEP_BIT  = 30
) (
  input  logic [WORD_BITS-2:0]                   la,
  input  logic                                   bit_set,
  input  logic [WORD_BITS-2:0]                   acc_in,
  input  logic [$clog2(2*WORD_BITS)-1:0]         limit_in,
  input  logic [WORD_BITS-1:0]                   e_in,
  output logic [WORD_BITS-2:0]                   acc_out,
  output logic [$clog2(2*WORD_BITS)-1:0]         limit_out,
  output logic [WORD_BITS-1:0]                   e_out,
  output logic                                   wrap_out
);

  localparam int W     = WORD_BITS;
  localparam int LIM_W = $clog2(2*WORD_BITS);

  logic [LIM_W-1:0] sh;
  logic [W-2:0]     t;
  logic [W-1:0]     sum;
  logic [W-1:0]     e_inc;

  always_comb begin
    sh    = limit_in - LIM_W'(STEP_BIT);
    t     = (sh >= LIM_W'(W)) ? '0 : (la >> sh);
    sum   = {1'b0, acc_in} + {1'b0, t};
    e_inc = e_in + W'(1);
    acc_out   = acc_in;
    limit_out = limit_in;
    e_out     = e_in;
    wrap_out  = 1'b0;
    if (bit_set) begin
      if (sum[W-1]) begin
        // carry past the top: halve both and rescale
        acc_out   = (acc_in >> 1) + (t >> 1);
        limit_out = limit_in + LIM_W'(1);
        e_out     = e_inc;
        wrap_out  = !e_in[W-1] && e_inc[W-1];
      end else begin
        acc_out = sum[W-2:0];
      end
    end
  end

endmodule

// ===== design/custom_float_add_sub_mul_core.sv =====
// ----------------------------------------------------------------------------
// custom_float_add_sub_mul_core
// Pipelined add / subtract / multiply / integer convert for a signed
// mantissa, signed exponent number format.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel req_valid/req_ready carries req_type, both operands and
//   the integer magnitude/sign; a transaction is taken when both are high.
//   Result channel res_valid/res_ready returns res_mantissa, res_exponent and
//   exponent_wrapped, one result per request, in request order.
//   Path: the decode stage loads at the transaction edge, then WORD_BITS-1
//   multiply bit stages (the first also does add/subtract alignment), six
//   normaliser stages and the output register. Every operation takes the
//   same path. Throughput: one transaction per cycle while results are
//   taken, set by one multiply bit per stage.
//   Receiver stall: the output register holds its result; stages behind it
//   keep advancing into empty slots, so requests are still taken until the
//   pipeline is full, then req_ready drops. Nothing is lost or repeated.
//   Reset (rst, synchronous): all valid bits clear, pipeline empties.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module custom_float_add_sub_mul_core #(
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] lhs_mantissa,
  input  logic signed [31:0] lhs_exponent,
  input  logic signed [31:0] rhs_mantissa,
  input  logic signed [31:0] rhs_exponent,
  input  logic [cfasm_pkg::INT_BITS-1:0] int_magnitude,
  input  logic               int_negative,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [31:0] res_mantissa,
  output logic signed [31:0] res_exponent,
  output logic               exponent_wrapped
);

  import cfasm_pkg::*;

  localparam int W      = WORD_BITS;
  localparam int LIM_W  = $clog2(2*WORD_BITS);     // multiply shift limit
  localparam int SH_W   = $clog2(WORD_BITS+1);     // saturated align shift
  localparam int NST    = WORD_BITS + NORM_STEPS;  // pipeline stages
  localparam int NSHIFT = INT_BITS + 1 - WORD_BITS; // mantissa pad in nv
  localparam logic [W-1:0] EXP_ZERO  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] CONV_BASE = W'(INT_BITS + 1 - WORD_BITS);

  // Per-stage record
  typedef struct packed {
    kind_t                  kind;
    logic                   neg;    // result sign (left sign for K_SUB pre-align)
    logic [W-2:0]           la;     // left magnitude
    logic [W-2:0]           ra;     // right magnitude
    logic [W-2:0]           acc;    // accumulator / add-sub magnitude
    logic [SH_W-1:0]        sha;    // left alignment shift, saturated at W
    logic [SH_W-1:0]        shb;    // right alignment shift
    logic [LIM_W-1:0]       limit;
    logic [W-1:0]           e;
    logic                   wrap;
    logic [INT_BITS-1:0]    nv;     // normaliser word
    logic [NORM_STEPS-1:0]  c;      // normaliser shift count
  } pipe_t;

  pipe_t          st  [NST];
  pipe_t          nxt [NST];
  logic [NST-1:0] vld;
  logic [NST:0]   en;
  kind_t          out_kind;

  // {overflow, sum} of two W-bit exponents
  function automatic logic [W:0] exp_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W-1:0] r;
    r = a + b;
    return {(a[W-1] == b[W-1]) && (r[W-1] != a[W-1]), r};
  endfunction

  // Magnitude of a W-bit mantissa, most negative value saturated
  function automatic logic [W-2:0] mag_of(input logic [W-1:0] v);
    logic [W-1:0] n;
    n = v[W-1] ? (~v + W'(1)) : v;
    return n[W-1] ? '1 : n[W-2:0];
  endfunction

  // Handshake: a stage loads when empty or when its successor moves on
  always_comb begin
    en[NST] = !res_valid || res_ready;
    for (int k = NST-1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end
  assign req_ready = en[0];

  // ---- stage 0: decode -----------------------------------------------------
  logic [W-1:0] lm, le, rm, re, pm, da, db;
  logic [W:0]   e1, e2;
  logic         same_sign;

  always_comb begin
    lm = W'(lhs_mantissa);
    le = W'(lhs_exponent);
    rm = W'(rhs_mantissa);
    re = W'(rhs_exponent);
    pm = ($signed(le) > $signed(re)) ? le : re;
    da = pm - le;
    db = pm - re;
    e1 = exp_add(le, re);
    e2 = exp_add(e1[W-1:0], W'(W-2));
    same_sign = (lm[W-1] == rm[W-1]);

    nxt[0].kind  = K_ADD;
    nxt[0].neg   = lm[W-1];
    nxt[0].la    = mag_of(lm);
    nxt[0].ra    = mag_of(rm);
    nxt[0].acc   = '0;
    nxt[0].sha   = (da >= W'(W)) ? SH_W'(W) : da[SH_W-1:0];
    nxt[0].shb   = (db >= W'(W)) ? SH_W'(W) : db[SH_W-1:0];
    nxt[0].limit = LIM_W'(W-2);
    nxt[0].e     = pm;
    nxt[0].wrap  = 1'b0;
    nxt[0].nv    = int_magnitude;
    nxt[0].c     = '0;
    unique case (req_t'(req_type))
      REQ_ADD: nxt[0].kind = same_sign ? K_ADD : K_SUB;
      REQ_SUB: nxt[0].kind = same_sign ? K_SUB : K_ADD;
      REQ_MUL: begin
        nxt[0].kind = K_MUL;
        nxt[0].neg  = lm[W-1] ^ rm[W-1];
        nxt[0].e    = e2[W-1:0];
        nxt[0].wrap = e1[W] | e2[W];
      end
      REQ_CONV: begin
        nxt[0].kind = K_CONV;
        nxt[0].neg  = int_negative;
      end
      default: nxt[0].kind = K_ADD;
    endcase
  end

  // ---- add / subtract on the stage 0 record (used by stage 1) ---------------
  logic [W-2:0] ax, ay, as_acc;
  logic [W-1:0] as_sum, as_e;
  logic [W:0]   as_einc;
  logic         as_wrap, as_neg;

  always_comb begin
    ax      = (st[0].sha >= SH_W'(W)) ? '0 : (st[0].la >> st[0].sha);
    ay      = (st[0].shb >= SH_W'(W)) ? '0 : (st[0].ra >> st[0].shb);
    as_sum  = {1'b0, ax} + {1'b0, ay};
    as_einc = exp_add(st[0].e, W'(1));
    as_acc  = as_sum[W-2:0];
    as_e    = st[0].e;
    as_wrap = 1'b0;
    as_neg  = st[0].neg;
    if (st[0].kind == K_SUB) begin
      as_acc = (ax < ay) ? (ay - ax) : (ax - ay);
      as_neg = st[0].neg ? (ax > ay) : (ax < ay);
    end else if (as_sum[W-1]) begin
      // carry: halve both aligned magnitudes and bump the exponent
      as_acc  = (ax >> 1) + (ay >> 1);
      as_e    = as_einc[W-1:0];
      as_wrap = as_einc[W];
    end
  end

  // ---- multiply bit stages and normaliser ----------------------------------
  for (genvar k = 1; k < NST; k++) begin : g_stage
    if (k < W) begin : g_mul
      logic [W-2:0]     m_acc;
      logic [LIM_W-1:0] m_limit;
      logic [W-1:0]     m_e;
      logic             m_wrap;

      cfasm_mul_step #(
        .WORD_BITS (WORD_BITS),
        .STEP_BIT  (WORD_BITS-1-k)
      ) u_step (
        .la        (st[k-1].la),
        .bit_set   (st[k-1].ra[W-1-k]),
        .acc_in    (st[k-1].acc),
        .limit_in  (st[k-1].limit),
        .e_in      (st[k-1].e),
        .acc_out   (m_acc),
        .limit_out (m_limit),
        .e_out     (m_e),
        .wrap_out  (m_wrap)
      );

      always_comb begin
        nxt[k] = st[k-1];
        if (st[k-1].kind == K_MUL) begin
          nxt[k].acc   = m_acc;
          nxt[k].limit = m_limit;
          nxt[k].e     = m_e;
          nxt[k].wrap  = st[k-1].wrap | m_wrap;
        end else if (k == 1) begin
          nxt[k].acc  = as_acc;
          nxt[k].e    = as_e;
          nxt[k].wrap = as_wrap;
          nxt[k].neg  = as_neg;
        end
        // last multiply stage loads the normaliser word
        if (k == W-1 && nxt[k].kind != K_CONV) begin
          nxt[k].nv = {nxt[k].acc, {NSHIFT{1'b0}}};
        end
      end
    end else begin : g_norm
      localparam int AMT = (INT_BITS/2) >> (k-W);
      always_comb begin
        nxt[k] = st[k-1];
        if (st[k-1].nv[INT_BITS-1 -: AMT] == '0) begin
          nxt[k].nv = st[k-1].nv << AMT;
          nxt[k].c  = st[k-1].c + NORM_STEPS'(AMT);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) vld[k] <= (k == 0) ? (req_valid && req_ready) : vld[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (en[k]) st[k] <= nxt[k];
    end
  end

  // ---- final assembly -------------------------------------------------------
  pipe_t        fs;
  logic [W-1:0] f_mag, f_m, f_e;
  logic [W:0]   f_adj;
  logic         f_zero, f_wrap;

  always_comb begin
    fs     = st[NST-1];
    f_zero = (fs.nv == '0);
    f_mag  = {1'b0, fs.nv[INT_BITS-1 -: W-1]};
    f_adj  = exp_add(fs.e, W'(0) - W'(fs.c));
    f_m    = '0;
    f_e    = EXP_ZERO;
    f_wrap = fs.wrap;
    unique case (fs.kind)
      K_ADD: begin
        f_m = fs.neg ? (W'(0) - {1'b0, fs.acc}) : {1'b0, fs.acc};
        f_e = fs.e;
      end
      K_SUB, K_MUL: begin
        if (!f_zero) begin
          f_m    = fs.neg ? (W'(0) - f_mag) : f_mag;
          f_e    = f_adj[W-1:0];
          f_wrap = fs.wrap | f_adj[W];
        end
      end
      K_CONV: begin
        f_wrap = 1'b0;
        if (!f_zero) begin
          f_m = fs.neg ? (W'(0) - f_mag) : f_mag;
          f_e = CONV_BASE - W'(fs.c);
        end
      end
      default: f_wrap = fs.wrap;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en[NST]) begin
      res_valid <= vld[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST]) begin
      res_mantissa     <= 32'(signed'(f_m));
      res_exponent     <= 32'(signed'(f_e));
      exponent_wrapped <= f_wrap;
      out_kind         <= fs.kind;
    end
  end

  // ---- checks ---------------------------------------------------------------
  // A taking receiver always frees the whole pipeline
  `ASSERT_IMP(a_ready_follows, clk, rst, res_ready, req_ready)
  // An accepted request lands in the decode stage
  `ASSERT_NXT(a_accept_lands, clk, rst, req_valid && req_ready, vld[0])
  // Integer conversion never reports an exponent wrap
  `ASSERT_IMP(a_conv_nowrap, clk, rst, res_valid && out_kind == K_CONV, !exponent_wrapped)

endmodule
